FILE: design/mbsp_pkg.sv
// Shared types, byte codes and the message length table of the MIDI byte stream parser.
package mbsp_pkg;

	localparam logic [7:0] STATUS_BIT = 8'h80;
	localparam logic [7:0] SX_START   = 8'hF0;
	localparam logic [7:0] SX_END     = 8'hF7;
	localparam logic [7:0] RT_FIRST   = 8'hF8;
	localparam logic [7:0] NO_STATUS  = 8'h00;

	localparam int unsigned RESULT_FIFO_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_SHORT  = 2'd0,
		KIND_RT     = 2'd1,
		KIND_SYSEX  = 2'd2,
		KIND_CANCEL = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		LEN_UNDEF = 2'd0,
		LEN_ONE   = 2'd1,
		LEN_TWO   = 2'd2,
		LEN_THREE = 2'd3
	} msg_len_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] status;
		logic [6:0] data1;
		logic [6:0] data2;
		logic       sysex_last;
	} result_t;

	// Results handed from the decoder to the result queue in one cycle.
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r1;
		result_t    r0;
	} push_t;

	function automatic msg_len_t msg_len(input logic [7:0] st);
		msg_len_t len;
		case (st) inside
			[8'h80:8'hBF]: len = LEN_THREE;
			[8'hC0:8'hDF]: len = LEN_TWO;
			[8'hE0:8'hEF]: len = LEN_THREE;
			8'hF1, 8'hF3:  len = LEN_TWO;
			8'hF2:         len = LEN_THREE;
			8'hF6:         len = LEN_ONE;
			default:       len = LEN_UNDEF;
		endcase
		return len;
	endfunction

	function automatic result_t make_result(input kind_t k, input logic [7:0] st,
		input logic [6:0] d1, input logic [6:0] d2, input logic last);
		result_t r;
		r.kind       = k;
		r.status     = st;
		r.data1      = d1;
		r.data2      = d2;
		r.sysex_last = last;
		return r;
	endfunction

endpackage

FILE: design/mbsp_decode.sv
// Parser state and the single-pass decode of one registered input word.
module mbsp_decode import mbsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       cmd_s1,
	input  logic [7:0] byte_s1,
	output push_t      push
);

	logic       in_sysex_q, in_sysex_d;
	logic [1:0] pend_cnt_q, pend_cnt_d;
	logic [7:0] pend_status_q, pend_status_d;
	logic [6:0] pend_data1_q, pend_data1_d;
	msg_len_t   len_b, len_p;
	result_t    res [2];
	logic [1:0] n;

	assign len_b = msg_len(byte_s1);
	assign len_p = msg_len(pend_status_q);

	always_comb begin
		in_sysex_d    = in_sysex_q;
		pend_cnt_d    = pend_cnt_q;
		pend_status_d = pend_status_q;
		pend_data1_d  = pend_data1_q;
		res[0]        = '0;
		res[1]        = '0;
		n             = 2'd0;
		if (cmd_s1) begin
			pend_cnt_d = 2'd0;
			if (in_sysex_q) begin
				res[0]     = make_result(KIND_CANCEL, NO_STATUS, 7'd0, 7'd0, 1'b0);
				n          = 2'd1;
				in_sysex_d = 1'b0;
			end
		end else if (byte_s1 >= RT_FIRST) begin
			res[0] = make_result(KIND_RT, byte_s1, 7'd0, 7'd0, 1'b0);
			n      = 2'd1;
		end else if (byte_s1 == SX_START) begin
			pend_cnt_d = 2'd0;
			in_sysex_d = 1'b1;
			if (in_sysex_q) begin
				res[0] = make_result(KIND_SYSEX, SX_END, 7'd0, 7'd0, 1'b1);
				res[1] = make_result(KIND_SYSEX, SX_START, 7'd0, 7'd0, 1'b0);
				n      = 2'd2;
			end else begin
				res[0] = make_result(KIND_SYSEX, SX_START, 7'd0, 7'd0, 1'b0);
				n      = 2'd1;
			end
		end else if (in_sysex_q && ((byte_s1 & STATUS_BIT) == 8'h00)) begin
			res[0] = make_result(KIND_SYSEX, byte_s1, 7'd0, 7'd0, 1'b0);
			n      = 2'd1;
		end else if (in_sysex_q && byte_s1 == SX_END) begin
			res[0]     = make_result(KIND_SYSEX, SX_END, 7'd0, 7'd0, 1'b1);
			n          = 2'd1;
			in_sysex_d = 1'b0;
		end else if ((byte_s1 & STATUS_BIT) != 8'h00) begin
			// Any other status closes an open SysEx stream first, then is parsed normally.
			if (in_sysex_q) begin
				res[0]     = make_result(KIND_SYSEX, SX_END, 7'd0, 7'd0, 1'b1);
				in_sysex_d = 1'b0;
			end
			pend_cnt_d = 2'd0;
			n = {1'b0, in_sysex_q} + {1'b0, (len_b == LEN_ONE)};
			if (len_b == LEN_ONE) begin
				res[in_sysex_q] = make_result(KIND_SHORT, byte_s1, 7'd0, 7'd0, 1'b0);
			end else if (len_b != LEN_UNDEF) begin
				pend_status_d = byte_s1;
				pend_data1_d  = 7'd0;
				pend_cnt_d    = 2'd1;
			end
		end else begin
			if (pend_cnt_q == 2'd1) begin
				pend_data1_d = byte_s1[6:0];
				if (len_p == LEN_TWO) begin
					res[0] = make_result(KIND_SHORT, pend_status_q, byte_s1[6:0], 7'd0, 1'b0);
					n          = 2'd1;
					pend_cnt_d = 2'd0;
				end else begin
					pend_cnt_d = 2'd2;
				end
			end else if (pend_cnt_q == 2'd2) begin
				res[0] = make_result(KIND_SHORT, pend_status_q, pend_data1_q, byte_s1[6:0],
					1'b0);
				n          = 2'd1;
				pend_cnt_d = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sysex_q    <= 1'b0;
			pend_cnt_q    <= 2'd0;
			pend_status_q <= 8'h00;
			pend_data1_q  <= 7'd0;
		end else if (adv) begin
			in_sysex_q    <= in_sysex_d;
			pend_cnt_q    <= pend_cnt_d;
			pend_status_q <= pend_status_d;
			pend_data1_q  <= pend_data1_d;
		end
	end

	assign push.cnt = adv ? n : 2'd0;
	assign push.r0  = res[0];
	assign push.r1  = res[1];

endmodule

FILE: design/mbsp_result_fifo.sv
// Small result queue that takes up to two results per cycle and hands out one per cycle while pop is high.
module mbsp_result_fifo import mbsp_pkg::*; #(
	parameter int unsigned DEPTH = RESULT_FIFO_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    pop,
	output logic    room2,
	output logic    not_empty,
	output result_t head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

	result_t        entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [CW-1:0]  count_q;
	logic           do_pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == LAST_PTR) ? '0 : p + PW'(1);
	endfunction

	assign wr_ptr_p1 = ptr_inc(wr_ptr_q);
	assign do_pop    = pop && not_empty;
	assign not_empty = (count_q != '0);
	assign room2     = (count_q <= ROOM_LIMIT);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			entry_q[wr_ptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			entry_q[wr_ptr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.cnt == 2'd1) begin
				wr_ptr_q <= wr_ptr_p1;
			end else if (push.cnt == 2'd2) begin
				wr_ptr_q <= ptr_inc(wr_ptr_p1);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push.cnt) - CW'(do_pop);
		end
	end

endmodule

FILE: design/midi_byte_stream_parser.sv
// Top level of the MIDI byte stream parser: input register, decoder and result queue.
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  command, data_byte
//  result    out        out_valid/out_stall  kind, status, data1, data2, sysex_last, source
//  config    in         cfg_wr_en            cfg_wr_data (source tag)
//
// A word is registered on acceptance and decoded from that register; when two queue entries
// are free it pushes up to two results into the queue, which holds four entries by default.
// One word per cycle is sustained while the output drains; the two results of one word
// leave by the single output port in turn, and the queue depth sets how long bursts last.
// in_stall rises while the registered word waits for two free queue entries.
// Reset clears the parser state and the queue at once; there is no clearing pass.
module midi_byte_stream_parser import mbsp_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = RESULT_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] status,
	output logic [6:0] data1,
	output logic [6:0] data2,
	output logic       sysex_last,
	output logic [3:0] source,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data
);

	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic [3:0] source_q;
	logic       room2, adv, in_accept;
	push_t      push;
	result_t    head;

	assign adv       = valid_s1 && room2;
	assign in_stall  = valid_s1 && !room2;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1  <= command;
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= 4'd0;
		end else if (cfg_wr_en) begin
			source_q <= cfg_wr_data;
		end
	end

	mbsp_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.cmd_s1  (cmd_s1),
		.byte_s1 (byte_s1),
		.push    (push)
	);

	mbsp_result_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (!out_stall),
		.room2     (room2),
		.not_empty (out_valid),
		.head      (head)
	);

	assign kind       = head.kind;
	assign status     = head.status;
	assign data1      = head.data1;
	assign data2      = head.data2;
	assign sysex_last = head.sysex_last;
	assign source     = source_q;

endmodule

FILE: design/mbsp_checker.sv
// Port-level checks of the MIDI byte stream parser, bound to the top level.
module mbsp_checker import mbsp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] kind,
	input logic [7:0] status,
	input logic [6:0] data1,
	input logic [6:0] data2,
	input logic       sysex_last
);

	// A stalled result word stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(status)
			&& $stable(data1) && $stable(data2) && $stable(sysex_last))
		else $error("result word changed while stalled");

	a_cancel_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_CANCEL |-> status == NO_STATUS && data1 == 7'd0
			&& data2 == 7'd0 && !sysex_last)
		else $error("cancel marker carries payload");

	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sysex_last |-> kind == KIND_SYSEX && status == SX_END)
		else $error("last flag on a word that is not a closing F7");

	a_rt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_RT |-> status >= RT_FIRST && data1 == 7'd0
			&& data2 == 7'd0 && !sysex_last)
		else $error("realtime word out of range");

	a_short_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_SHORT |-> status[7] && !sysex_last)
		else $error("short message without a status byte");

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (.*);
